// ===== hdl/sliding_window_aggregate_macros.svh =====
// Assertion wrappers; empty when SYNTHESIS is defined.
`ifndef SLIDING_WINDOW_AGGREGATE_MACROS_SVH
`define SLIDING_WINDOW_AGGREGATE_MACROS_SVH

`ifndef SYNTHESIS

`define SWA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding window aggregate: assertion failed");

`define SWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window aggregate: assertion failed");

`else

`define SWA_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SWA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/swa_pkg.sv =====
package swa_pkg;

   localparam int WINDOW_MAX        = 256;
   localparam int SAMPLE_BITS       = 32;
   localparam int SAMPLE_FIELD_BITS = 32;
   localparam int OUT_BITS          = 40;

   localparam int PTR_BITS  = $clog2(WINDOW_MAX);
   localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int WIN_BITS  = 9;
   localparam int MODE_BITS = 2;
   localparam int CMP_BITS  = (WIN_BITS > CNT_BITS) ? WIN_BITS : CNT_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int REM_BITS  = CNT_BITS + 1;
   localparam int STEP_BITS = $clog2(SUM_BITS + 1);
   localparam int WIDE_BITS = (SUM_BITS + 1 > OUT_BITS + 1) ? SUM_BITS + 1 : OUT_BITS + 1;

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = WIN_BITS;

   localparam logic [CSR_IDX_BITS-1:0] REG_MODE       = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_WINDOW_LEN = 1'd1;

   localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_AVG = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SUM = 2'd3;

   localparam logic [WIN_BITS-1:0] WIN_RESET = 9'd1;

   localparam logic signed [WIDE_BITS-1:0] WIDE_OUT_MAX =
      {{(WIDE_BITS - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}};
   localparam logic signed [WIDE_BITS-1:0] WIDE_OUT_MIN =
      {{(WIDE_BITS - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}};

   function automatic logic [PTR_BITS-1:0] ptr_prev(input logic [PTR_BITS-1:0] p);
      return (p == '0) ? PTR_BITS'(WINDOW_MAX - 1) : p - 1'b1;
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic signed [OUT_BITS-1:0] clamp_out(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] c;
      if (v > WIDE_OUT_MAX) begin
         c = WIDE_OUT_MAX;
      end else if (v < WIDE_OUT_MIN) begin
         c = WIDE_OUT_MIN;
      end else begin
         c = v;
      end
      return c[OUT_BITS-1:0];
   endfunction

endpackage

// ===== hdl/swa_if.sv =====
interface swa_req_if import swa_pkg::*; ();
   logic                                valid;
   logic                                ready;
   logic signed [SAMPLE_FIELD_BITS-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink (input valid, sample, output ready);
endinterface

interface swa_rsp_if import swa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] aggregate;

   modport source (output valid, aggregate, input ready);
   modport sink (input valid, aggregate, output ready);
endinterface

// ===== hdl/sliding_window_aggregate.sv =====
// Sliding-window aggregate: each sample accepted on req_if yields one result on rsp_if, the
// maximum (floored at 0), minimum, truncating average or sum of the up to window_len samples
// that came before it (0 when there are none); the sample is then stored in a 256-entry ring.
// A sample is accepted only while idle, so no new sample is taken until the last is done:
// its n = min(window_len, samples stored so far) stored samples are read one per cycle from
// the single read port of the ring memory, average then runs the one-bit-per-cycle divider,
// and an empty window skips the scan. The ring needs no clearing pass after reset. A finished
// result waits in the output register while the next sample is accepted.
`include "sliding_window_aggregate_macros.svh"

module sliding_window_aggregate import swa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   swa_req_if.sink                  req_if,
   swa_rsp_if.source                rsp_if
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_SCAN     = 5'b00010,
      ST_DIV_INIT = 5'b00100,
      ST_DIV      = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic [WIN_BITS-1:0]  window_len_ff, window_len_in;
   logic [PTR_BITS-1:0]  write_ptr_ff, write_ptr_in;
   logic [CNT_BITS-1:0]  fill_ff, fill_in;
   logic [PTR_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic [CNT_BITS-1:0]  issue_left_ff, issue_left_in;
   logic [CNT_BITS-1:0]  recv_left_ff, recv_left_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic [SAMPLE_BITS-1:0]        sample_ff, sample_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic                          first_ff, first_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SUM_BITS-1:0]           dvd_ff, dvd_in;
   logic [REM_BITS-1:0]           rem_ff, rem_in;
   logic                          div_neg_ff, div_neg_in;
   logic signed [OUT_BITS-1:0]    rsp_data_ff, rsp_data_in;

   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [SAMPLE_BITS-1:0]        ram_rd_data;
   logic                          out_free;
   logic [CNT_BITS-1:0]           count_now;
   logic signed [SAMPLE_BITS-1:0] rd_value;
   logic [REM_BITS-1:0]           rem_shift;
   logic                          rem_ge;
   logic signed [WIDE_BITS-1:0]   quot_mag;
   logic signed [WIDE_BITS-1:0]   quot_signed;
   logic signed [OUT_BITS-1:0]    result;

   swa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_ptr_ff),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.aggregate = rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign ram_rd_en = (state_ff == ST_SCAN) && (issue_left_ff != '0);
   assign ram_wr_en = (state_ff == ST_FINISH) && out_free;
   assign rd_value  = $signed(ram_rd_data);

   assign count_now = (CMP_BITS'(window_len_ff) < CMP_BITS'(fill_ff)) ?
                      CNT_BITS'(window_len_ff) : fill_ff;

   assign rem_shift = {rem_ff[REM_BITS-2:0], dvd_ff[SUM_BITS-1]};
   assign rem_ge    = (rem_shift >= REM_BITS'(count_ff));

   assign quot_mag    = $signed(WIDE_BITS'(dvd_ff));
   assign quot_signed = div_neg_ff ? -quot_mag : quot_mag;

   always_comb begin
      case (mode_ff)
         MODE_MAX: result = OUT_BITS'(max_ff);
         MODE_MIN: result = OUT_BITS'(min_ff);
         MODE_AVG: result = clamp_out(quot_signed);
         MODE_SUM: result = clamp_out(WIDE_BITS'(sum_ff));
         default:  result = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      window_len_in = window_len_ff;
      write_ptr_in  = write_ptr_ff;
      fill_in       = fill_ff;
      rd_addr_in    = rd_addr_ff;
      issue_left_in = issue_left_ff;
      recv_left_in  = recv_left_ff;
      rd_valid_in   = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      step_in       = step_ff;
      sample_in     = sample_ff;
      count_in      = count_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      first_in      = first_ff;
      sum_in        = sum_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      div_neg_in    = div_neg_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_index)
            REG_MODE:       mode_in = csr_wdata[MODE_BITS-1:0];
            REG_WINDOW_LEN: window_len_in = csr_wdata[WIN_BITS-1:0];
            default:        ;
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               sample_in     = req_if.sample[SAMPLE_BITS-1:0];
               count_in      = count_now;
               issue_left_in = count_now;
               recv_left_in  = count_now;
               rd_addr_in    = ptr_prev(write_ptr_ff);
               max_in        = '0;
               min_in        = '0;
               first_in      = 1'b1;
               sum_in        = '0;
               dvd_in        = '0;
               div_neg_in    = 1'b0;
               state_in      = (count_now == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = ram_rd_en;
            if (ram_rd_en) begin
               issue_left_in = issue_left_ff - 1'b1;
               rd_addr_in    = ptr_prev(rd_addr_ff);
            end
            if (rd_valid_ff) begin
               if (rd_value > max_ff) begin
                  max_in = rd_value;
               end
               if (first_ff || rd_value < min_ff) begin
                  min_in = rd_value;
               end
               first_in     = 1'b0;
               sum_in       = sum_ff + SUM_BITS'(rd_value);
               recv_left_in = recv_left_ff - 1'b1;
               if (recv_left_ff == CNT_BITS'(1)) begin
                  state_in = (mode_ff == MODE_AVG) ? ST_DIV_INIT : ST_FINISH;
               end
            end
         end
         ST_DIV_INIT: begin
            div_neg_in = sum_ff[SUM_BITS-1];
            dvd_in     = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
            rem_in     = '0;
            step_in    = STEP_BITS'(SUM_BITS);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_shift - REM_BITS'(count_ff) : rem_shift;
            dvd_in  = {dvd_ff[SUM_BITS-2:0], rem_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               write_ptr_in = ptr_next(write_ptr_ff);
               if (fill_ff < CNT_BITS'(WINDOW_MAX)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_MAX;
         window_len_ff <= WIN_RESET;
         write_ptr_ff  <= '0;
         fill_ff       <= '0;
         rd_addr_ff    <= '0;
         issue_left_ff <= '0;
         recv_left_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         window_len_ff <= window_len_in;
         write_ptr_ff  <= write_ptr_in;
         fill_ff       <= fill_in;
         rd_addr_ff    <= rd_addr_in;
         issue_left_ff <= issue_left_in;
         recv_left_ff  <= recv_left_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      count_ff    <= count_in;
      max_ff      <= max_in;
      min_ff      <= min_in;
      first_ff    <= first_in;
      sum_ff      <= sum_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_neg_ff  <= div_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SWA_ASSERT_IMPL(a_wr_not_during_scan, clock, reset, ram_wr_en, !ram_rd_en)
   `SWA_ASSERT_IMPL(a_fill_bounded, clock, reset, 1'b1, fill_ff <= CNT_BITS'(WINDOW_MAX))
   `SWA_ASSERT_IMPL(a_reads_in_order, clock, reset, state_ff == ST_SCAN, recv_left_ff >= issue_left_ff)
   `SWA_ASSERT_NEXT(a_finish_delivers, clock, reset, ram_wr_en, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// ===== hdl/swa_ram.sv =====
module swa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/tb.sv =====
module tb;
   import swa_pkg::*;

   localparam int     DIRECTED_ROWS = 23;
   localparam int     RANDOM_ITEMS  = 700;
   localparam int     STALL_LIMIT   = 4000;
   localparam int     SETTLE_CYCLES = 4;
   localparam longint AGG_HIGH      = (64'sd1 <<< (OUT_BITS - 1)) - 1;
   localparam longint AGG_LOW       = -AGG_HIGH - 1;

   typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_e;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TWO_OF_THREE} ready_style_e;

   typedef struct packed {
      row_kind_e                           kind;
      logic [MODE_BITS-1:0]                mode;
      logic [WIN_BITS-1:0]                 span;
      logic signed [SAMPLE_FIELD_BITS-1:0] sample;
      logic                                pinned;
      logic signed [OUT_BITS-1:0]          want;
   } stim_row_t;

   typedef struct packed {
      logic                       pinned;
      logic signed [OUT_BITS-1:0] value;
   } typed_result_t;

   localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, MODE_MAX, 9'd0,   32'sd5,            1'b1, 40'sd0},
      '{ROW_SAMPLE, MODE_MAX, 9'd0,   -32'sd7,           1'b1, 40'sd5},
      '{ROW_SAMPLE, MODE_MAX, 9'd0,   32'sh7FFF_FFFF,    1'b1, 40'sd0},
      '{ROW_SAMPLE, MODE_MAX, 9'd0,   32'sh8000_0000,    1'b1, 40'sd2147483647},
      '{ROW_CONFIG, MODE_MIN, 9'd256, 32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_MIN, 9'd0,   32'sd1,            1'b1, -40'sd2147483648},
      '{ROW_CONFIG, MODE_SUM, 9'd511, 32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_SUM, 9'd0,   -32'sd1,           1'b1, -40'sd2},
      '{ROW_CONFIG, MODE_AVG, 9'd511, 32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_AVG, 9'd0,   32'sd3,            1'b0, 40'sd0},
      '{ROW_CONFIG, MODE_AVG, 9'd0,   32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_AVG, 9'd0,   32'sd100,          1'b1, 40'sd0},
      '{ROW_CONFIG, MODE_MAX, 9'd0,   32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_MAX, 9'd0,   -32'sd100,         1'b1, 40'sd0},
      '{ROW_CONFIG, MODE_MIN, 9'd2,   32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_MIN, 9'd0,   32'sd0,            1'b0, 40'sd0},
      '{ROW_CONFIG, MODE_AVG, 9'd2,   32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_AVG, 9'd0,   32'sh8000_0000,    1'b0, 40'sd0},
      '{ROW_CONFIG, MODE_SUM, 9'd256, 32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_SUM, 9'd0,   32'sh7FFF_FFFF,    1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_SUM, 9'd0,   32'sh7FFF_FFFF,    1'b0, 40'sd0},
      '{ROW_CONFIG, MODE_MAX, 9'd256, 32'sd0,            1'b0, 40'sd0},
      '{ROW_SAMPLE, MODE_MAX, 9'd0,   32'sh5555_AAAA,    1'b0, 40'sd0}
   };

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   swa_req_if req_ch ();
   swa_rsp_if rsp_ch ();

   sliding_window_aggregate dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   logic signed [SAMPLE_FIELD_BITS-1:0] sample_history [WINDOW_MAX];
   int unsigned                         history_head  = 0;
   int unsigned                         history_count = 0;
   logic [MODE_BITS-1:0]                agg_mode      = MODE_MAX;
   logic [WIN_BITS-1:0]                 agg_span      = WIN_RESET;

   logic signed [OUT_BITS-1:0] expected_aggregates [$];
   typed_result_t              typed_results [$];

   int           failures      = 0;
   int           results_seen  = 0;
   int           samples_sent  = 0;
   int           settings_made = 0;
   int           mode_hits [4] = '{0, 0, 0, 0};
   int           idle_cycles   = 0;
   int           burst_left    = 0;
   int           stall_left    = 0;
   int unsigned  stall_tick    = 0;
   ready_style_e stall_style   = READY_ALWAYS;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic signed [OUT_BITS-1:0] window_aggregate(
      input logic signed [SAMPLE_FIELD_BITS-1:0] s);
      longint      acc;
      longint      hi;
      longint      lo;
      longint      v;
      longint      r;
      int unsigned n;
      int unsigned slot;
      n    = (agg_span < history_count) ? agg_span : history_count;
      slot = history_head;
      acc  = 0;
      hi   = 0;
      lo   = 0;
      r    = 0;
      for (int unsigned k = 0; k < n; k++) begin
         slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
         v    = sample_history[slot];
         if (v > hi) hi = v;
         if (k == 0 || v < lo) lo = v;
         acc += v;
      end
      if (n != 0) begin
         case (agg_mode)
            MODE_MAX: r = hi;
            MODE_MIN: r = lo;
            MODE_AVG: r = acc / longint'(n);
            default:  r = acc;
         endcase
         if (r > AGG_HIGH) r = AGG_HIGH;
         if (r < AGG_LOW) r = AGG_LOW;
      end
      sample_history[history_head] = s;
      history_head = (history_head == WINDOW_MAX - 1) ? 0 : history_head + 1;
      if (history_count < WINDOW_MAX) history_count++;
      return r[OUT_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_FIELD_BITS-1:0] random_sample();
      int          pick;
      int          v;
      logic [15:0] half;
      pick = $urandom_range(0, 99);
      half = 16'($urandom);
      if (pick < 40) begin
         v = $urandom;
      end else if (pick < 60) begin
         v = int'($urandom_range(0, 200)) - 100;
      end else if (pick < 70) begin
         v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else if (pick < 85) begin
         v = (pick % 2) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                        : 32'h8000_0000 + $urandom_range(0, 15);
      end else begin
         v = {{16{half[15]}}, half};
      end
      return v;
   endfunction

   function automatic logic [WIN_BITS-1:0] random_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return WIN_BITS'($urandom_range(1, 8));
      if (pick < 75) return WIN_BITS'($urandom_range(9, 64));
      if (pick < 85) return WIN_BITS'($urandom_range(65, 255));
      if (pick < 92) return WIN_BITS'(WINDOW_MAX);
      if (pick < 96) return WIN_BITS'($urandom_range(257, 511));
      return '0;
   endfunction

   task automatic settle_idle();
      req_ch.valid = 1'b0;
      while (expected_aggregates.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_window(input logic [MODE_BITS-1:0] m, input logic [WIN_BITS-1:0] w);
      settle_idle();
      csr_wr_en = 1'b1;
      csr_index = REG_MODE;
      csr_wdata = {7'($urandom), m};
      @(negedge clock);
      csr_index = REG_WINDOW_LEN;
      csr_wdata = w;
      @(negedge clock);
      csr_wr_en = 1'b0;
      agg_mode  = m;
      agg_span  = w;
      settings_made++;
   endtask

   task automatic push_sample(input logic signed [SAMPLE_FIELD_BITS-1:0] s,
                              input logic pinned, input logic signed [OUT_BITS-1:0] want);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      typed_results.push_back('{pinned, want});
      req_ch.valid  = 1'b1;
      req_ch.sample = s;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      samples_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = ready_style_e'($urandom_range(0, 3));
         stall_left  = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_style)
         READY_ALWAYS: rsp_ch.ready = 1'b1;
         READY_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ch.ready = (stall_tick % 8 == 0);
         default:      rsp_ch.ready = (stall_tick % 3 != 0);
      endcase
   end

   always @(posedge clock) begin : result_check
      logic signed [OUT_BITS-1:0] want;
      logic signed [OUT_BITS-1:0] predicted;
      typed_result_t              note;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_aggregates.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got %0d",
                        $time, rsp_ch.aggregate);
               failures++;
            end else begin
               want = expected_aggregates.pop_front();
               if (rsp_ch.aggregate !== want) begin
                  $display("%0t: aggregate mismatch, expected %0d, got %0d",
                           $time, want, rsp_ch.aggregate);
                  failures++;
               end
               results_seen++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            mode_hits[agg_mode]++;
            predicted = window_aggregate(req_ch.sample);
            note      = typed_results.pop_front();
            expected_aggregates.push_back(note.pinned ? note.value : predicted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("sliding_window_aggregate test failed");
            $finish;
         end
      end
   end

   initial begin
      int random_items;
      int phase_len;
      clock         = 1'b0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = REG_MODE;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      random_items  = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_CONFIG) begin
            program_window(DIRECTED[r].mode, DIRECTED[r].span);
         end else begin
            push_sample(DIRECTED[r].sample, DIRECTED[r].pinned, DIRECTED[r].want);
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         program_window(MODE_BITS'($urandom_range(0, 3)), random_span());
         phase_len = $urandom_range(10, 40);
         for (int i = 0; i < phase_len; i++) begin
            push_sample(random_sample(), 1'b0, '0);
            random_items++;
            if ($urandom_range(0, 39) == 0) settle_idle();
         end
      end

      settle_idle();
      repeat (20) @(negedge clock);
      $display("covered %0d samples and %0d checked results over %0d window settings",
               samples_sent, results_seen, settings_made);
      $display("samples per mode max/min/avg/sum: %0d/%0d/%0d/%0d, mismatches: %0d",
               mode_hits[MODE_MAX], mode_hits[MODE_MIN], mode_hits[MODE_AVG],
               mode_hits[MODE_SUM], failures);
      if (failures == 0) begin
         $display("sliding_window_aggregate test passed");
      end else begin
         $display("sliding_window_aggregate test failed");
      end
      $finish;
   end

endmodule
